[hw/rtl/ptor_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the peer table with oldest-entry replacement.
package ptor_pkg;

   localparam int TableDepth = 32;
   localparam int IdxW       = $clog2(TableDepth);
   localparam int CntW       = $clog2(TableDepth + 1);
   localparam int IndexW     = 8;
   localparam int AddrW      = 3;

   localparam logic [1:0] ACT_RECORD = 2'd0;
   localparam logic [1:0] ACT_READ   = 2'd1;
   localparam logic [1:0] ACT_COUNT  = 2'd2;

   localparam logic REG_OWN_ID = 1'b0;
   localparam logic REG_WINDOW = 1'b1;

   localparam logic [31:0]        WindowReset = 32'd30000;
   localparam logic signed [7:0]  NoRssi      = -8'sd127;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [31:0]       peer_id;
      logic signed [7:0] rssi;
      logic [31:0]       now_ms;
      logic [IndexW-1:0] index;
   } req_type;

   typedef struct packed {
      logic [31:0]       entry_id;
      logic signed [7:0] entry_rssi;
      logic [31:0]       entry_age_ms;
      logic [5:0]        nearby_count;
      logic [5:0]        stored_count;
      logic              was_new;
      logic              was_self;
   } rsp_type;

   typedef struct packed {
      logic [31:0]       id;
      logic [31:0]       seen;
      logic signed [7:0] rssi;
   } entry_type;

endpackage

[hw/rtl/peer_table_oldest_replace.sv]
`timescale 1ns / 1ps
// Peer table: sighting record, entry read and nearby count over a scanned slot memory.
//
// A request is taken when start is high and busy is low; busy stays high until
// the single response has been issued. A sighting or count walks the occupied
// slots, and an in-range entry read fetches only its slot, through one read
// port of the slot memory, one slot per cycle, with one shared 32-bit
// subtractor doing either the wrap-aware age compare (oldest search) or the
// now-minus-seen age. A self sighting, an out-of-range read, an unused action
// code or a sighting or count on an empty table fetches no slot. The response
// is on rsp_data when rsp_strobe is high for a single cycle; the receiver
// cannot stall it, and the next request may be taken in that same cycle. Slots
// have no reset: only slots below the stored count are ever used. Configuration
// (own_id at 0x0, nearby window at 0x4, reset 30000) may be written only while
// busy is low.
module peer_table_oldest_replace
   import ptor_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   // response channel
   output logic             rsp_strobe,
   output rsp_type          rsp_data,
   // register port
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [AddrW-1:0] paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   // slot memory
   entry_type mem [TableDepth];
   entry_type rd_ff;
   logic [IdxW-1:0] rd_addr;
   logic            wr_en;
   logic [IdxW-1:0] wr_addr;
   entry_type       wr_data;

   // control
   state_type      state_ff, state_in;
   req_type        cmd_ff, cmd_in;
   logic           self_ff, self_in;
   logic [CntW-1:0] scan_idx_ff, scan_idx_in;
   logic [CntW-1:0] scan_end_ff, scan_end_in;
   logic           proc_vld_ff, proc_vld_in;
   logic [IdxW-1:0] proc_idx_ff, proc_idx_in;
   logic [CntW-1:0] fill_ff, fill_in;

   // scan results
   logic            hit_ff, hit_in;
   logic [IdxW-1:0] hit_idx_ff, hit_idx_in;
   logic [IdxW-1:0] best_idx_ff, best_idx_in;
   logic [31:0]     best_seen_ff, best_seen_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [31:0]     res_id_ff, res_id_in;
   logic signed [7:0] res_rssi_ff, res_rssi_in;
   logic [31:0]     res_age_ff, res_age_in;

   // output and registers
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;
   logic [31:0]    own_id_ff, window_ff;

   // shared subtractor
   logic [31:0] sub_a, sub_b, diff;
   logic        issue;
   logic [IdxW-1:0] slot;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign pready     = 1'b1;
   assign prdata     = (paddr[2] == REG_WINDOW) ? window_ff : own_id_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= '0;
         window_ff <= WindowReset;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == REG_WINDOW) begin
            window_ff <= pwdata;
         end else begin
            own_id_ff <= pwdata;
         end
      end
   end

   // slot memory: one registered read, one write
   assign rd_addr = scan_idx_ff[IdxW-1:0];

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Oldest search compares the fetched slot with the best so far;
   // age paths take now minus the fetched slot time.
   always_comb begin
      if (cmd_ff.action == ACT_RECORD) begin
         sub_a = rd_ff.seen;
         sub_b = best_seen_ff;
      end else begin
         sub_a = cmd_ff.now_ms;
         sub_b = rd_ff.seen;
      end
      diff = sub_a - sub_b;
   end

   assign issue = (scan_idx_ff < scan_end_ff);

   // replacement slot: refresh a hit, else append, else evict the oldest
   always_comb begin
      if (hit_ff) begin
         slot = hit_idx_ff;
      end else if (fill_ff < CntW'(TableDepth)) begin
         slot = fill_ff[IdxW-1:0];
      end else begin
         slot = best_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         proc_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         proc_vld_ff  <= proc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      self_ff      <= self_in;
      scan_idx_ff  <= scan_idx_in;
      scan_end_ff  <= scan_end_in;
      proc_idx_ff  <= proc_idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      best_idx_ff  <= best_idx_in;
      best_seen_ff <= best_seen_in;
      cnt_ff       <= cnt_in;
      res_id_ff    <= res_id_in;
      res_rssi_ff  <= res_rssi_in;
      res_age_ff   <= res_age_in;
      rsp_ff       <= rsp_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      self_in      = self_ff;
      scan_idx_in  = scan_idx_ff;
      scan_end_in  = scan_end_ff;
      proc_vld_in  = 1'b0;
      proc_idx_in  = proc_idx_ff;
      fill_in      = fill_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      best_idx_in  = best_idx_ff;
      best_seen_in = best_seen_ff;
      cnt_in       = cnt_ff;
      res_id_in    = res_id_ff;
      res_rssi_in  = res_rssi_ff;
      res_age_in   = res_age_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = slot;
      wr_data      = '{id: cmd_ff.peer_id, seen: cmd_ff.now_ms, rssi: cmd_ff.rssi};

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in      = req_data;
               self_in     = 1'b0;
               scan_idx_in = '0;
               scan_end_in = '0;
               hit_in      = 1'b0;
               cnt_in      = '0;
               // out-of-range read answer, replaced if the slot is fetched
               res_id_in   = '0;
               res_rssi_in = NoRssi;
               res_age_in  = req_data.now_ms;
               case (req_data.action)
                  ACT_RECORD: begin
                     if (req_data.peer_id == own_id_ff) begin
                        self_in = 1'b1;
                     end else begin
                        scan_end_in = fill_ff;
                     end
                  end
                  ACT_READ: begin
                     if (req_data.index < IndexW'(fill_ff)) begin
                        scan_idx_in = CntW'(req_data.index);
                        scan_end_in = CntW'(req_data.index) + CntW'(1);
                     end
                  end
                  ACT_COUNT: begin
                     scan_end_in = fill_ff;
                  end
                  default: begin
                  end
               endcase
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            proc_vld_in = issue;
            proc_idx_in = scan_idx_ff[IdxW-1:0];
            if (issue) begin
               scan_idx_in = scan_idx_ff + CntW'(1);
            end
            if (proc_vld_ff) begin
               case (cmd_ff.action)
                  ACT_RECORD: begin
                     if (!hit_ff && (rd_ff.id == cmd_ff.peer_id)) begin
                        hit_in     = 1'b1;
                        hit_idx_in = proc_idx_ff;
                     end
                     // strictly older only, so the lowest index keeps ties
                     if ((proc_idx_ff == '0) || diff[31]) begin
                        best_idx_in  = proc_idx_ff;
                        best_seen_in = rd_ff.seen;
                     end
                  end
                  ACT_READ: begin
                     res_id_in   = rd_ff.id;
                     res_rssi_in = rd_ff.rssi;
                     res_age_in  = diff;
                  end
                  ACT_COUNT: begin
                     if (diff <= window_ff) begin
                        cnt_in = cnt_ff + CntW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (!issue && !proc_vld_ff) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            rsp_in = '0;
            case (cmd_ff.action)
               ACT_RECORD: begin
                  if (self_ff) begin
                     rsp_in.was_self = 1'b1;
                  end else begin
                     wr_en          = 1'b1;
                     rsp_in.was_new = !hit_ff;
                     if (!hit_ff && (fill_ff < CntW'(TableDepth))) begin
                        fill_in = fill_ff + CntW'(1);
                     end
                  end
               end
               ACT_READ: begin
                  rsp_in.entry_id     = res_id_ff;
                  rsp_in.entry_rssi   = res_rssi_ff;
                  rsp_in.entry_age_ms = res_age_ff;
               end
               ACT_COUNT: begin
                  rsp_in.nearby_count = 6'(cnt_ff);
               end
               default: begin
               end
            endcase
            rsp_in.stored_count = 6'(fill_in);
            rsp_valid_in        = 1'b1;
            state_in            = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
